// ----- rtl/core/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, codes and the segment pattern table for the seven segment
// value multiplexer.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int VALUE_W = 18;
	localparam int SEG_W   = 7;
	localparam int SEL_W   = 4;
	localparam int DIGIT_W = 4;

	localparam logic [1:0] PHASE_DIGIT1 = 2'd0;
	localparam logic [1:0] PHASE_DIGIT2 = 2'd1;
	localparam logic [1:0] PHASE_DIGIT3 = 2'd2;
	localparam logic [1:0] PHASE_DEGREE = 2'd3;

	localparam logic [1:0] POINT_NONE   = 2'd0;
	localparam logic [1:0] POINT_DIGIT2 = 2'd1;
	localparam logic [1:0] POINT_DIGIT1 = 2'd2;

	localparam logic [SEL_W-1:0] SEL_DEGREE = 4'b1000;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_hundredths;
		logic [1:0]                phase;
	} sample_t;

	typedef struct packed {
		logic [SEL_W-1:0] digit_select;
		logic [SEG_W-1:0] segments;
		logic             decimal_point;
		logic             degree_led;
	} display_t;

	typedef struct packed {
		logic               negative;
		logic [1:0]         point_pos;
		logic [DIGIT_W-1:0] hundreds;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
	} digits_t;

	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0:    p = 7'd125;
			4'd1:    p = 7'd9;
			4'd2:    p = 7'd103;
			4'd3:    p = 7'd47;
			4'd4:    p = 7'd27;
			4'd5:    p = 7'd62;
			4'd6:    p = 7'd126;
			4'd7:    p = 7'd13;
			4'd8:    p = 7'd127;
			4'd9:    p = 7'd63;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/svm_digits.sv -----
// ----------------------------------------------------------------------------
// svm_digits
// Splits a value in hundredths into three decimal digits and picks the
// decimal point position.
// ----------------------------------------------------------------------------
module svm_digits (
	input  logic signed [svm_pkg::VALUE_W-1:0] value_hundredths,
	output svm_pkg::digits_t                   digits
);

	logic [16:0] raw;
	logic [34:0] prod100;
	logic [33:0] prod10;
	logic [10:0] whole;
	logic [9:0]  tenths;
	logic [9:0]  shown;
	logic [1:0]  point_pos;
	logic [15:0] prod_h;
	logic [3:0]  hund;
	logic [6:0]  rest;
	logic [13:0] prod_t;
	logic [3:0]  tens;
	logic [3:0]  units;

	assign raw = value_hundredths[16:0];

	// reciprocal multiplies, exact over the 17-bit range
	assign prod100 = {18'd0, raw} * 35'd167773;
	assign whole   = prod100[34:24];
	assign prod10  = {17'd0, raw} * 34'd104858;
	assign tenths  = prod10[29:20];

	always_comb begin
		if (whole >= 11'd100) begin
			point_pos = svm_pkg::POINT_NONE;
			if (whole >= 11'd1000) begin
				shown = 10'(whole - 11'd1000);
			end else begin
				shown = whole[9:0];
			end
		end else if (whole >= 11'd10) begin
			point_pos = svm_pkg::POINT_DIGIT2;
			shown     = tenths;
		end else begin
			point_pos = svm_pkg::POINT_DIGIT1;
			shown     = raw[9:0];
		end
	end

	assign prod_h = {6'd0, shown} * 16'd41;
	assign hund   = prod_h[15:12];
	assign rest   = 7'(shown - 10'(hund * 7'd100));
	assign prod_t = {7'd0, rest} * 14'd103;
	assign tens   = prod_t[13:10];
	assign units  = 4'(rest - 7'(tens * 4'd10));

	always_comb begin
		digits.negative  = value_hundredths[svm_pkg::VALUE_W-1];
		digits.point_pos = point_pos;
		if (value_hundredths[svm_pkg::VALUE_W-1]) begin
			digits.hundreds = '0;
			digits.tens     = '0;
			digits.units    = '0;
		end else begin
			digits.hundreds = hund;
			digits.tens     = tens;
			digits.units    = units;
		end
	end

endmodule

// ----- rtl/core/svm_update.sv -----
// ----------------------------------------------------------------------------
// svm_update
// Works out the next contents of the display lines from the phase, the
// digits and the lines as they stand.
// ----------------------------------------------------------------------------
module svm_update (
	input  logic [1:0]        phase,
	input  svm_pkg::digits_t  digits,
	input  svm_pkg::display_t current,
	output svm_pkg::display_t next
);

	logic [svm_pkg::DIGIT_W-1:0] d;

	always_comb begin
		case (phase)
			svm_pkg::PHASE_DIGIT1: d = digits.hundreds;
			svm_pkg::PHASE_DIGIT2: d = digits.tens;
			default:               d = digits.units;
		endcase
	end

	always_comb begin
		next = current;
		if (phase == svm_pkg::PHASE_DEGREE) begin
			if (digits.negative) begin
				next.segments      = '0;
				next.decimal_point = 1'b0;
				next.degree_led    = 1'b0;
			end else begin
				next.digit_select = svm_pkg::SEL_DEGREE;
				next.degree_led   = 1'b1;
			end
		end else begin
			next.digit_select = 4'(1 << phase);
			next.degree_led   = 1'b0;
			if (digits.negative) begin
				next.segments      = '0;
				next.decimal_point = 1'b0;
			end else begin
				next.segments      = svm_pkg::seg_pattern(d);
				next.decimal_point =
					(phase == svm_pkg::PHASE_DIGIT1 &&
					 digits.point_pos == svm_pkg::POINT_DIGIT1) ||
					(phase == svm_pkg::PHASE_DIGIT2 &&
					 digits.point_pos == svm_pkg::POINT_DIGIT2);
			end
		end
	end

endmodule

// ----- rtl/core/seven_segment_value_multiplexer.sv -----
// ----------------------------------------------------------------------------
// seven_segment_value_multiplexer
// Shows a signed value in hundredths on three seven segment digits and a
// degree symbol, one refresh phase per request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  sample    in   sample_valid / sample_stall  svm_pkg::sample_t
//  display   out  display_valid / display_stall svm_pkg::display_t
//
//  one request per cycle while the display side does not stall; a request is
//  registered in the input stage, and its result then in the result register
//  the display lines are held in the result register between requests
//  reset clears the lines and empties both stages
//  a stalled result holds the input stage, which then stalls the sample side
// ----------------------------------------------------------------------------
module seven_segment_value_multiplexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  svm_pkg::sample_t  sample,
	output logic              display_valid,
	input  logic              display_stall,
	output svm_pkg::display_t display
);

	logic              valid_s1;
	svm_pkg::sample_t  sample_s1;
	logic              advance;
	svm_pkg::digits_t  digits;
	svm_pkg::display_t lines_q;
	svm_pkg::display_t lines_next;
	logic              display_valid_q;

	assign advance      = valid_s1 && !(display_valid_q && display_stall);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	svm_digits u_digits (
		.value_hundredths (sample_s1.value_hundredths),
		.digits           (digits)
	);

	svm_update u_update (
		.phase   (sample_s1.phase),
		.digits  (digits),
		.current (lines_q),
		.next    (lines_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q         <= '0;
			display_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				lines_q         <= lines_next;
				display_valid_q <= 1'b1;
			end else if (!display_stall) begin
				display_valid_q <= 1'b0;
			end
		end
	end

	assign display_valid = display_valid_q;
	assign display       = lines_q;

endmodule
